>>> hw/rtl/ssu_pkg.sv
// Shared constants and types for the state update and accumulate unit.
package ssu_pkg;

  localparam int DATA_W       = 16;
  localparam int COL_W        = 8;
  localparam int COLUMNS_DEF  = 256;
  localparam int ACT_W        = 18;
  localparam int EXP_W        = 20;
  localparam int POLY_W       = 24;

  // Clamp limits and values of the exponent approximation.
  localparam logic signed [ACT_W-1:0] T_HI     = 18'sd12288;
  localparam logic signed [ACT_W-1:0] T_LO     = -18'sd12288;
  localparam logic [EXP_W-1:0]        EXP_POS3 = 20'd82270;
  localparam logic [EXP_W-1:0]        EXP_NEG3 = 20'd203;
  localparam logic [POLY_W-1:0]       POLY_ONE = 24'h010000;

  // Item leaving the arithmetic pipeline toward the accumulate stage.
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] new_state;
    logic signed [31:0]       prod;
    logic signed [DATA_W-1:0] gate;
    logic [COL_W-1:0]         column;
    logic                     first_row;
    logic                     last_row;
  } ssu_tail_t;

  // Item one stage earlier, used to issue the column read.
  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] column;
  } ssu_lookup_t;

endpackage

>>> hw/rtl/ssu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ssu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/ssu_datapath.sv
// Six-stage arithmetic pipeline computing the new state and its product with c.
module ssu_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  logic                             in_valid,
  input  logic signed [ssu_pkg::DATA_W-1:0] old_state,
  input  logic signed [ssu_pkg::DATA_W-1:0] decay_coef,
  input  logic signed [ssu_pkg::DATA_W-1:0] step_size,
  input  logic signed [ssu_pkg::DATA_W-1:0] input_coef,
  input  logic signed [ssu_pkg::DATA_W-1:0] output_coef,
  input  logic signed [ssu_pkg::DATA_W-1:0] input_term,
  input  logic signed [ssu_pkg::DATA_W-1:0] gate_value,
  input  logic [ssu_pkg::COL_W-1:0]         column,
  input  logic                             first_row,
  input  logic                             last_row,
  output ssu_pkg::ssu_lookup_t             lookup,
  output ssu_pkg::ssu_tail_t               tail
);

  import ssu_pkg::*;

  logic [6:1] v;

  logic signed [DATA_W-1:0] h0_1, h0_2, h0_3;
  logic signed [DATA_W-1:0] c_1, c_2, c_3, c_4, c_5;
  logic signed [DATA_W-1:0] x_1;
  logic signed [DATA_W-1:0] g_1, g_2, g_3, g_4, g_5, g_6;
  logic [COL_W-1:0]         col_1, col_2, col_3, col_4, col_5, col_6;
  logic [6:1]               first_p, last_p;

  logic signed [35:0] tprod_1;
  logic signed [31:0] bd_1;
  logic signed [ACT_W-1:0] t_2;
  logic signed [35:0] tsq_2;
  logic signed [47:0] bdx_2, bdx_3, bdx_4;
  logic [EXP_W-1:0]   e_3;
  logic signed [31:0] h0e_4;
  logic signed [DATA_W-1:0] h1d_5, h1d_6;
  logic signed [31:0] p_6;

  logic signed [ACT_W-1:0] a_act, dl_act, t_c;
  logic signed [POLY_W-1:0] tp, tt, y;
  logic [EXP_W-1:0]   e_c;
  logic signed [36:0] h0e_c;
  logic signed [31:0] h1_c;

  assign a_act  = {decay_coef, 2'b00};
  assign dl_act = {step_size, 2'b00};
  assign t_c    = tprod_1[29:12];

  // Second-order exponent polynomial with clamping and a floor at zero.
  always_comb begin
    tp = {{2{t_2[ACT_W-1]}}, t_2, 4'b0000};
    tt = tsq_2[31:8];
    y  = POLY_ONE + tp + {tt[POLY_W-1], tt[POLY_W-1:1]};
    if (t_2 > T_HI) begin
      e_c = EXP_POS3;
    end else if (t_2 < T_LO) begin
      e_c = EXP_NEG3;
    end else if (y[POLY_W-1]) begin
      e_c = '0;
    end else begin
      e_c = y[POLY_W-1:4];
    end
  end

  assign h0e_c = h0_3 * $signed({1'b0, e_3});
  assign h1_c  = h0e_4 + bdx_4[39:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (advance) begin
      v <= {v[5:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tprod_1 <= a_act * dl_act;
      bd_1    <= step_size * input_coef;
      h0_1    <= old_state;
      c_1     <= output_coef;
      x_1     <= input_term;
      g_1     <= gate_value;
      col_1   <= column;

      t_2   <= t_c;
      tsq_2 <= t_c * t_c;
      bdx_2 <= bd_1 * x_1;
      h0_2  <= h0_1;
      c_2   <= c_1;
      g_2   <= g_1;
      col_2 <= col_1;

      e_3   <= e_c;
      bdx_3 <= bdx_2;
      h0_3  <= h0_2;
      c_3   <= c_2;
      g_3   <= g_2;
      col_3 <= col_2;

      h0e_4 <= h0e_c[31:0];
      bdx_4 <= bdx_3;
      c_4   <= c_3;
      g_4   <= g_3;
      col_4 <= col_3;

      h1d_5 <= h1_c[27:12];
      c_5   <= c_4;
      g_5   <= g_4;
      col_5 <= col_4;

      p_6   <= h1d_5 * c_5;
      h1d_6 <= h1d_5;
      g_6   <= g_5;
      col_6 <= col_5;

      first_p <= {first_p[5:1], first_row};
      last_p  <= {last_p[5:1], last_row};
    end
  end

  assign lookup.valid  = v[5];
  assign lookup.column = col_5;

  assign tail.valid     = v[6];
  assign tail.new_state = h1d_6;
  assign tail.prod      = p_6;
  assign tail.gate      = g_6;
  assign tail.column    = col_6;
  assign tail.first_row = first_p[6];
  assign tail.last_row  = last_p[6];

endmodule

>>> hw/rtl/ssm_state_update_accumulate_unit.sv
// Top level of the selective-scan state update and per-column accumulate unit.
// Each request carries one state element of one row at one column; the unit
// computes h1 = h0*exp_approx(a*delta) + b*delta*x, returns it as new_state, and
// adds h1*c to a per-column running sum (the first row starts that sum from
// zero). On the last row it also returns gate plus the updated sum in
// layer_output with output_valid set; otherwise layer_output is zero. A request
// is taken every cycle while item_stall is low and passes through six
// arithmetic stages (the product a*delta, its square, and the clamped
// polynomial for the exponent, then the decay product, the state sum, and the
// product with c) followed by the accumulate stage, which reads the column sum
// from a RAM and feeds back the sum written by the request just ahead when both
// hit the same column. Column sums read as zero after reset through per-entry
// valid bits, so no clearing pass is needed.
// Columns at or above COLUMNS read as zero and are not written.
module ssm_state_update_accumulate_unit #(
  parameter int COLUMNS = ssu_pkg::COLUMNS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic signed [ssu_pkg::DATA_W-1:0] old_state,
  input  logic signed [ssu_pkg::DATA_W-1:0] decay_coef,
  input  logic signed [ssu_pkg::DATA_W-1:0] step_size,
  input  logic signed [ssu_pkg::DATA_W-1:0] input_coef,
  input  logic signed [ssu_pkg::DATA_W-1:0] output_coef,
  input  logic signed [ssu_pkg::DATA_W-1:0] input_term,
  input  logic signed [ssu_pkg::DATA_W-1:0] gate_value,
  input  logic [ssu_pkg::COL_W-1:0]         column,
  input  logic                              first_row,
  input  logic                              last_row,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [ssu_pkg::DATA_W-1:0] new_state,
  output logic signed [ssu_pkg::DATA_W-1:0] layer_output,
  output logic                              output_valid
);

  import ssu_pkg::*;

  localparam int AW = $clog2(COLUMNS > 1 ? COLUMNS : 2);

  ssu_lookup_t lookup;
  ssu_tail_t   tail;

  // The whole pipeline moves together whenever the output register can take a result.
  logic advance;
  assign advance    = !result_valid || !result_stall;
  assign item_stall = !advance;

  ssu_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .in_valid    (item_valid),
    .old_state   (old_state),
    .decay_coef  (decay_coef),
    .step_size   (step_size),
    .input_coef  (input_coef),
    .output_coef (output_coef),
    .input_term  (input_term),
    .gate_value  (gate_value),
    .column      (column),
    .first_row   (first_row),
    .last_row    (last_row),
    .lookup      (lookup),
    .tail        (tail)
  );

  logic              look_in_range, tail_in_range;
  logic [AW-1:0]     look_addr, tail_addr;
  logic [COLUMNS-1:0] written;
  logic              written_q;
  logic              fwd_hit;
  logic [DATA_W-1:0] fwd_data;
  logic [DATA_W-1:0] ram_q;
  logic [DATA_W-1:0] base, sum;
  logic              wr_en;

  assign look_in_range = 32'(lookup.column) < COLUMNS;
  assign tail_in_range = 32'(tail.column) < COLUMNS;
  assign look_addr     = AW'(lookup.column);
  assign tail_addr     = AW'(tail.column);

  // The accumulate stage writes its column as the result moves to the output register.
  assign wr_en = advance && tail.valid && tail_in_range;

  ssu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (COLUMNS)
  ) u_sums (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_addr),
    .wr_data (sum),
    .rd_en   (advance),
    .rd_addr (look_addr),
    .rd_data (ram_q)
  );

  // The read for the next request happens at the same edge as the write of
  // this one, so a same-column pair takes the sum straight from the write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
      fwd_hit   <= 1'b0;
    end else if (advance) begin
      if (wr_en) begin
        written[tail_addr] <= 1'b1;
      end
      written_q <= look_in_range && written[look_addr];
      fwd_hit   <= wr_en && lookup.valid && (lookup.column == tail.column);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fwd_data <= sum;
    end
  end

  always_comb begin
    if (tail.first_row || !tail_in_range) begin
      base = '0;
    end else if (fwd_hit) begin
      base = fwd_data;
    end else if (written_q) begin
      base = ram_q;
    end else begin
      base = '0;
    end
    sum = base + tail.prod[25:10];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      new_state    <= tail.new_state;
      layer_output <= tail.last_row ? $signed(tail.gate + sum) : '0;
      output_valid <= tail.last_row;
    end
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");
  a_not_last_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !output_valid) |-> (layer_output == '0))
    else $error("layer output nonzero on a row that is not last");
  a_fwd_needs_item: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> tail.valid)
    else $error("sum forwarded to an empty accumulate stage");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> $stable(new_state) && $stable(layer_output))
    else $error("result changed while stalled");
`endif

endmodule
